>>> rtl/video_quality_level_adaptation_assert.svh
// assertion macros shared by the video quality level adaptation rtl
`ifndef VIDEO_QUALITY_LEVEL_ADAPTATION_ASSERT_SVH
`define VIDEO_QUALITY_LEVEL_ADAPTATION_ASSERT_SVH
`ifndef ASSERT_OFF
`define VQLA_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: always");
`define VQLA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");
`define VQLA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next cycle");
`else
`define VQLA_ASSERT_ALWAYS(label, clk, rst, cond)
`define VQLA_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define VQLA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/vqla_pkg.sv
// types, codes and profile tables for the video quality level adaptation block
package vqla_pkg;

   localparam logic [1:0] CMD_UPDATE    = 2'd0;
   localparam logic [1:0] CMD_RESET_NET = 2'd1;
   localparam logic [1:0] CMD_EMERGENCY = 2'd2;

   localparam logic [3:0]  LEVEL_MAX        = 4'd8;
   localparam logic [2:0]  RECOVERY_WINDOWS = 3'd5;
   localparam logic [2:0]  RTT_CONFIRM      = 3'd5;
   localparam logic [1:0]  LOSS_CONFIRM     = 2'd3;
   localparam logic [10:0] CAP_MIN          = 11'd60;
   localparam logic [10:0] CAP_MAX          = 11'd2000;
   localparam logic [10:0] CAP_RESET        = 11'd2000;

   typedef struct packed {
      logic [1:0]  command;
      logic        report_valid;
      logic [13:0] loss_hundredths;
      logic [19:0] rtt_sixteenths_ms;
   } req_type;

   typedef struct packed {
      logic [3:0]  quality_level;
      logic [10:0] capped_kbps;
      logic        emergency_active;
   } rsp_type;

   // classified request as it sits in the queue
   typedef struct packed {
      logic [1:0] command;
      logic       report_valid;
      logic [3:0] loss_raw;
      logic       loss_ge5000;
      logic       loss_gt6000;
      logic       loss_gt5500;
      logic       loss_ge1200;
      logic       loss_ge300;
      logic [2:0] rtt_raw;
   } cls_type;

   function automatic logic [10:0] rate_of(input logic [3:0] level);
      logic [10:0] rate;
      unique case (level)
         4'd0:    rate = 11'd2000;
         4'd1:    rate = 11'd900;
         4'd2:    rate = 11'd700;
         4'd3:    rate = 11'd500;
         4'd4:    rate = 11'd350;
         4'd5:    rate = 11'd220;
         4'd6:    rate = 11'd150;
         4'd7:    rate = 11'd90;
         default: rate = 11'd60;
      endcase
      return rate;
   endfunction

   function automatic logic [10:0] cap_clamp(input logic [10:0] cap);
      logic [10:0] c;
      if (cap < CAP_MIN) begin
         c = CAP_MIN;
      end else if (cap > CAP_MAX) begin
         c = CAP_MAX;
      end else begin
         c = cap;
      end
      return c;
   endfunction

   // lowest level whose profile rate fits under the clamped cap
   function automatic logic [3:0] first_level(input logic [10:0] cap);
      logic [3:0] lvl;
      lvl = LEVEL_MAX;
      for (int i = 7; i >= 0; i--) begin
         if (rate_of(4'(i)) <= cap) begin
            lvl = 4'(i);
         end
      end
      return lvl;
   endfunction

endpackage

>>> rtl/vqla_front.sv
// front end: takes requests and classifies loss and rtt against fixed thresholds
module vqla_front
   import vqla_pkg::*;
(
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   input  logic    q_full,
   output logic    push,
   output cls_type push_data
);

   logic [13:0] l;
   logic [19:0] r;

   assign l = req_payload.loss_hundredths;
   assign r = req_payload.rtt_sixteenths_ms;

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   always_comb begin
      push_data              = '0;
      push_data.command      = req_payload.command;
      push_data.report_valid = req_payload.report_valid;
      priority if (l > 14'd7700) begin
         push_data.loss_raw = 4'd8;
      end else if (l > 14'd7200) begin
         push_data.loss_raw = 4'd7;
      end else if (l > 14'd6500) begin
         push_data.loss_raw = 4'd6;
      end else if (l > 14'd5000) begin
         push_data.loss_raw = 4'd5;
      end else if (l > 14'd3000) begin
         push_data.loss_raw = 4'd4;
      end else if (l > 14'd2000) begin
         push_data.loss_raw = 4'd3;
      end else if (l > 14'd1500) begin
         push_data.loss_raw = 4'd2;
      end else if (l > 14'd500) begin
         push_data.loss_raw = 4'd1;
      end else begin
         push_data.loss_raw = 4'd0;
      end
      push_data.loss_ge5000 = (l >= 14'd5000);
      push_data.loss_gt6000 = (l > 14'd6000);
      push_data.loss_gt5500 = (l > 14'd5500);
      push_data.loss_ge1200 = (l >= 14'd1200);
      push_data.loss_ge300  = (l >= 14'd300);
      priority if (r > 20'd6400) begin
         push_data.rtt_raw = 3'd7;
      end else if (r > 20'd4800) begin
         push_data.rtt_raw = 3'd6;
      end else if (r > 20'd3520) begin
         push_data.rtt_raw = 3'd5;
      end else if (r > 20'd2560) begin
         push_data.rtt_raw = 3'd3;
      end else begin
         push_data.rtt_raw = 3'd0;
      end
   end

endmodule

>>> rtl/vqla_queue.sv
// two-entry queue between the classifying front end and the state back end
`include "video_quality_level_adaptation_assert.svh"
module vqla_queue
   import vqla_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cls_type push_data,
   input  logic    pop,
   output logic    q_valid,
   output logic    q_full,
   output cls_type q_data
);

   cls_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign q_valid = (count_ff != 2'd0);
   assign q_full  = (count_ff == 2'd2);
   assign q_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `VQLA_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= 2'd2)
   `VQLA_ASSERT_ALWAYS(a_ptr_match, clock, reset, (wr_ptr_ff ^ rd_ptr_ff) == count_ff[0])
   `VQLA_ASSERT_NEXT(a_push_only, clock, reset, push && !pop, count_ff == $past(count_ff) + 2'd1)

endmodule

>>> rtl/vqla_back.sv
// back end: confirmation counters, level state and the registered response
`include "video_quality_level_adaptation_assert.svh"
module vqla_back
   import vqla_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data,
   input  logic        q_valid,
   input  cls_type     q_data,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload
);

   logic [10:0] cap_ff;
   logic [3:0]  level_ff, level_in;
   logic [2:0]  healthy_ff, healthy_in;
   logic        emergency_ff, emergency_in;
   logic [2:0]  rtt_cand_ff, rtt_cand_in;
   logic [2:0]  rtt_count_ff, rtt_count_in;
   logic [2:0]  rtt_conf_ff, rtt_conf_in;
   logic [2:0]  loss_cand_ff, loss_cand_in;
   logic [1:0]  loss_count_ff, loss_count_in;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;

   logic [10:0] cap_used;
   logic [3:0]  cap_level;
   logic [3:0]  csr_level;
   logic        bump;
   logic [2:0]  bump_cand;
   logic [3:0]  lr_base, lr_hi, lr_lo;
   logic [2:0]  u_loss_cand;
   logic [1:0]  u_loss_count;
   logic [3:0]  lr_upd, lr_net;
   logic [2:0]  u_rtt_cand, u_rtt_count, u_rtt_conf;
   logic [3:0]  req_upd, req_net;
   logic [10:0] rate;
   logic        emerg_pop;

   assign cap_used  = cap_clamp(cap_ff);
   assign cap_level = first_level(cap_used);
   assign csr_level = first_level(cap_clamp(csr_wr_data));
   assign pop       = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign emerg_pop = pop && !csr_wr_en && q_data.command == CMD_EMERGENCY;

   // loss mapping with confirmation for levels two and five
   always_comb begin
      bump      = 1'b0;
      bump_cand = 3'd0;
      lr_base   = 4'd0;
      lr_hi     = 4'd0;
      lr_lo     = 4'd0;
      priority if (q_data.loss_raw >= 4'd6) begin
         lr_base = q_data.loss_raw;
      end else if (level_ff >= 4'd5 && q_data.loss_ge5000) begin
         lr_base = 4'd5;
      end else if (q_data.loss_raw == 4'd5) begin
         priority if (q_data.loss_gt6000) begin
            lr_base = 4'd5;
         end else if (q_data.loss_gt5500) begin
            bump      = 1'b1;
            bump_cand = 3'd5;
            lr_hi     = 4'd5;
            lr_lo     = 4'd4;
         end else begin
            lr_base = 4'd4;
         end
      end else if (q_data.loss_raw >= 4'd3) begin
         lr_base = q_data.loss_raw;
      end else if (q_data.loss_raw == 4'd2) begin
         if (level_ff >= 4'd2) begin
            lr_base = 4'd2;
         end else begin
            bump      = 1'b1;
            bump_cand = 3'd2;
            lr_hi     = 4'd2;
            lr_lo     = 4'd1;
         end
      end else if (level_ff >= 4'd2 && q_data.loss_ge1200) begin
         lr_base = 4'd2;
      end else if (q_data.loss_raw == 4'd1) begin
         lr_base = 4'd1;
      end else if (level_ff >= 4'd1 && q_data.loss_ge300) begin
         lr_base = 4'd1;
      end else begin
         lr_base = 4'd0;
      end

      if (!bump) begin
         u_loss_cand  = 3'd0;
         u_loss_count = 2'd0;
      end else if (loss_cand_ff == bump_cand) begin
         u_loss_cand  = loss_cand_ff;
         u_loss_count = (loss_count_ff == LOSS_CONFIRM) ? loss_count_ff : loss_count_ff + 2'd1;
      end else begin
         u_loss_cand  = bump_cand;
         u_loss_count = 2'd1;
      end

      lr_upd = bump ? ((u_loss_count >= LOSS_CONFIRM) ? lr_hi : lr_lo) : lr_base;
      lr_net = bump ? lr_lo : lr_base;
   end

   // rtt confirmation
   always_comb begin
      if (q_data.rtt_raw == 3'd0) begin
         u_rtt_cand  = 3'd0;
         u_rtt_count = 3'd0;
         u_rtt_conf  = 3'd0;
      end else begin
         if (q_data.rtt_raw == rtt_cand_ff) begin
            u_rtt_cand  = rtt_cand_ff;
            u_rtt_count = (rtt_count_ff == 3'd7) ? rtt_count_ff : rtt_count_ff + 3'd1;
         end else begin
            u_rtt_cand  = q_data.rtt_raw;
            u_rtt_count = 3'd1;
         end
         if (u_rtt_count >= RTT_CONFIRM) begin
            u_rtt_conf = u_rtt_cand;
         end else if (rtt_conf_ff > q_data.rtt_raw) begin
            u_rtt_conf = q_data.rtt_raw;
         end else begin
            u_rtt_conf = rtt_conf_ff;
         end
      end
      req_upd = (lr_upd > {1'b0, u_rtt_conf}) ? lr_upd : {1'b0, u_rtt_conf};
      req_net = (lr_net > cap_level) ? lr_net : cap_level;
   end

   always_comb begin
      level_in      = level_ff;
      healthy_in    = healthy_ff;
      emergency_in  = emergency_ff;
      rtt_cand_in   = rtt_cand_ff;
      rtt_count_in  = rtt_count_ff;
      rtt_conf_in   = rtt_conf_ff;
      loss_cand_in  = loss_cand_ff;
      loss_count_in = loss_count_ff;
      if (q_data.command == CMD_UPDATE && q_data.report_valid) begin
         rtt_cand_in   = u_rtt_cand;
         rtt_count_in  = u_rtt_count;
         rtt_conf_in   = u_rtt_conf;
         loss_cand_in  = u_loss_cand;
         loss_count_in = u_loss_count;
         priority if (req_upd > level_ff) begin
            level_in     = req_upd;
            healthy_in   = 3'd0;
            emergency_in = (req_upd == LEVEL_MAX);
         end else if (req_upd < level_ff) begin
            if (healthy_ff + 3'd1 >= RECOVERY_WINDOWS) begin
               level_in   = level_ff - 4'd1;
               healthy_in = 3'd0;
               if (level_ff - 4'd1 <= req_upd) begin
                  emergency_in = 1'b0;
               end
            end else begin
               healthy_in = healthy_ff + 3'd1;
            end
         end else begin
            healthy_in = 3'd0;
            if (req_upd < LEVEL_MAX) begin
               emergency_in = 1'b0;
            end
         end
      end else if (q_data.command == CMD_RESET_NET && q_data.report_valid) begin
         rtt_cand_in   = 3'd0;
         rtt_count_in  = 3'd0;
         rtt_conf_in   = 3'd0;
         loss_cand_in  = 3'd0;
         loss_count_in = 2'd0;
         level_in      = req_net;
         healthy_in    = 3'd0;
         emergency_in  = 1'b0;
      end else if (q_data.command == CMD_EMERGENCY) begin
         level_in     = LEVEL_MAX;
         healthy_in   = 3'd0;
         rtt_cand_in  = 3'd0;
         rtt_count_in = 3'd0;
         rtt_conf_in  = 3'd0;
         emergency_in = 1'b1;
      end

      rate                    = rate_of(level_in);
      rsp_in.quality_level    = level_in;
      rsp_in.capped_kbps      = (rate > cap_used) ? cap_used : rate;
      rsp_in.emergency_active = emergency_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= CAP_RESET;
         level_ff      <= first_level(CAP_RESET);
         healthy_ff    <= 3'd0;
         emergency_ff  <= 1'b0;
         rtt_cand_ff   <= 3'd0;
         rtt_count_ff  <= 3'd0;
         rtt_conf_ff   <= 3'd0;
         loss_cand_ff  <= 3'd0;
         loss_count_ff <= 2'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff        <= csr_wr_data;
            level_ff      <= csr_level;
            healthy_ff    <= 3'd0;
            emergency_ff  <= 1'b0;
            rtt_cand_ff   <= 3'd0;
            rtt_count_ff  <= 3'd0;
            rtt_conf_ff   <= 3'd0;
            loss_cand_ff  <= 3'd0;
            loss_count_ff <= 2'd0;
         end else if (pop) begin
            level_ff      <= level_in;
            healthy_ff    <= healthy_in;
            emergency_ff  <= emergency_in;
            rtt_cand_ff   <= rtt_cand_in;
            rtt_count_ff  <= rtt_count_in;
            rtt_conf_ff   <= rtt_conf_in;
            loss_cand_ff  <= loss_cand_in;
            loss_count_ff <= loss_count_in;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `VQLA_ASSERT_ALWAYS(a_level_range, clock, reset, level_ff <= LEVEL_MAX)
   `VQLA_ASSERT_ALWAYS(a_rtt_conf_order, clock, reset, rtt_conf_ff <= rtt_cand_ff)
   `VQLA_ASSERT_NEXT(a_force_emerg, clock, reset, emerg_pop, level_ff == LEVEL_MAX && emergency_ff)

endmodule

>>> rtl/video_quality_level_adaptation.sv
// Video quality level adaptation, top level.
// req_ channel: one network report per request (command, report_valid, loss in
//   hundredths of a percent, rtt in sixteenths of a ms); taken when req_valid is
//   high and req_stall is low.
// rsp_ channel: exactly one response per request, in order, with quality level,
//   bitrate limited to the cap and the emergency flag; taken when rsp_valid is
//   high and rsp_stall is low.
// csr_ port: csr_wr_en writes the bitrate cap and reinitialises the level state;
//   write only while no request is outstanding.
// Order: a request is classified and queued at the edge it is taken and leaves
//   the queue when its response is registered, once the response register is free;
//   the response is presented from that edge and can be taken at the next one.
// Throughput: one request per cycle while rsp_stall is low, set by the state update
//   in the back end; a two-entry queue sits between classification and state update.
// Stall: while rsp_stall is high the response register holds; the queue then
//   fills and req_stall rises once both entries are taken.
// Reset (synchronous, active high): cap 2000 kbps, level 0, all counters clear,
//   queue and response register empty.
module video_quality_level_adaptation
   import vqla_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data
);

   logic    push;
   cls_type push_data;
   logic    pop;
   logic    q_valid;
   logic    q_full;
   cls_type q_data;

   vqla_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_full      (q_full),
      .push        (push),
      .push_data   (push_data)
   );

   vqla_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_full    (q_full),
      .q_data    (q_data)
   );

   vqla_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_valid     (q_valid),
      .q_data      (q_data),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
